### design/prl_pkg.sv
// Shared types and codes for the positional record list.
package prl_pkg;

    // Control words carry counts up to the largest supported capacity (256)
    localparam int CTL_W = 9;

    // Cap on search hits reported per search command
    localparam int MAX_RESULTS = 16;
    localparam int N_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [9:0] RATING_MAX = 10'd1000;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADPOS  = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        logic [63:0] title;
        logic [63:0] genre;
        logic [15:0] year;
        logic [9:0]  rating;
    } rec_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t         op;
        logic [CTL_W-1:0] pos;
        logic [CTL_W-1:0] count;
    } cell_ctl_t;

endpackage

### design/prl_cell.sv
// One slot of the record chain: holds a record and trades it with its neighbors.
module prl_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                clk,
    input  prl_pkg::rec_t       left_rec,
    input  prl_pkg::rec_t       right_rec,
    input  prl_pkg::rec_t       head_rec,
    input  prl_pkg::rec_t       new_rec,
    input  prl_pkg::cell_ctl_t  ctl,
    output prl_pkg::rec_t       rec
);

    localparam logic [prl_pkg::CTL_W-1:0] IDX    = prl_pkg::CTL_W'(CELL_INDEX);
    localparam logic [prl_pkg::CTL_W-1:0] IDX_P1 = prl_pkg::CTL_W'(CELL_INDEX + 1);

    prl_pkg::rec_t data_reg;
    prl_pkg::rec_t data_next;

    // Pick the source for this slot
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            prl_pkg::CELL_INSERT:
            begin
                if (IDX == ctl.pos)
                    data_next = new_rec;
                else if (IDX > ctl.pos && IDX <= ctl.count)
                    data_next = left_rec;
            end
            prl_pkg::CELL_DELETE:
            begin
                if (IDX >= ctl.pos && IDX_P1 < ctl.count)
                    data_next = right_rec;
            end
            prl_pkg::CELL_ROTATE:
            begin
                if (IDX_P1 < ctl.count)
                    data_next = right_rec;
                else if (IDX_P1 == ctl.count)
                    data_next = head_rec;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the record
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rec = data_reg;

endmodule

### design/positional_record_list_top.sv
// Positional record list: controller and chain of record cells.
// Insert, a refused command or a search of an empty list answers in the cycle after start
// with busy low; read, delete and search hold busy while the list rotates once through
// the cell chain past slot 0, and delete and search then pass through a finish state.
// Each search hit is held until the next one is found in the rotation, the final one after it.
// Reset empties the list and clears the strobe; record contents are not reset.
module positional_record_list_top #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [4:0]  position,
    input  logic [63:0] title_key,
    input  logic [63:0] genre_key,
    input  logic [15:0] year,
    input  logic [9:0]  rating_tenths,
    output logic        valid,
    output logic [1:0]  status,
    output logic [3:0]  entry_position,
    output logic [63:0] entry_title,
    output logic [63:0] entry_genre,
    output logic [15:0] entry_year,
    output logic [9:0]  entry_rating,
    output logic [4:0]  entry_count,
    output logic        last
);

    localparam int CTL_W = prl_pkg::CTL_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int N_W   = prl_pkg::N_W;
    localparam logic [CTL_W-1:0] CAP_W = CTL_W'(CAPACITY);

    // Control state
    prl_pkg::fsm_t      state_reg, state_next;
    prl_pkg::cmd_t      cmd_reg, cmd_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [63:0]        key_reg, key_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [N_W-1:0]     n_reg, n_next;
    prl_pkg::rec_t      pend_rec_reg, pend_rec_next;
    logic [IDX_W-1:0]   pend_pos_reg, pend_pos_next;

    // Result beat registers
    logic               valid_reg;
    prl_pkg::status_t   status_reg;
    logic [3:0]         pos_out_reg;
    prl_pkg::rec_t      rec_out_reg;
    logic [4:0]         count_out_reg;
    logic               last_reg;

    logic               out_load;
    prl_pkg::status_t   out_status;
    logic [3:0]         out_pos;
    prl_pkg::rec_t      out_rec;
    logic [4:0]         out_count;
    logic               out_last;

    prl_pkg::cell_ctl_t ctl;
    prl_pkg::rec_t      new_rec;
    prl_pkg::rec_t      head;
    prl_pkg::rec_t      cell_q [CAPACITY];

    logic [CTL_W-1:0]   pos_w;
    logic [CTL_W-1:0]   count_w;
    logic [CTL_W-1:0]   count_inc_w;
    logic [CTL_W-1:0]   count_dec_w;
    logic [CTL_W-1:0]   k_w;
    logic [CTL_W-1:0]   pend_pos_w;
    prl_pkg::cmd_t      cmd_in;

    assign pos_w       = CTL_W'(position);
    assign count_w     = CTL_W'(count_reg);
    assign count_inc_w = count_w + CTL_W'(1);
    assign count_dec_w = count_w - CTL_W'(1);
    assign k_w         = CTL_W'(k_reg);
    assign pend_pos_w  = CTL_W'(pend_pos_reg);
    assign cmd_in      = prl_pkg::cmd_t'(command);
    assign head        = cell_q[0];

    // Build the record as stored, with the rating saturated
    always_comb
    begin
        new_rec.title  = title_key;
        new_rec.genre  = genre_key;
        new_rec.year   = year;
        new_rec.rating = (rating_tenths > prl_pkg::RATING_MAX) ? prl_pkg::RATING_MAX
                                                               : rating_tenths;
    end

    // Cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        prl_pkg::rec_t left_rec;
        prl_pkg::rec_t right_rec;

        if (i == 0)
        begin : g_first
            assign left_rec = '0;
        end
        else
        begin : g_inner_l
            assign left_rec = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_rec = '0;
        end
        else
        begin : g_inner_r
            assign right_rec = cell_q[i+1];
        end

        prl_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .left_rec  (left_rec),
            .right_rec (right_rec),
            .head_rec  (head),
            .new_rec   (new_rec),
            .ctl       (ctl),
            .rec       (cell_q[i])
        );
    end

    // Sequence commands and pick the result beat
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        k_next        = k_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        pend_rec_next = pend_rec_reg;
        pend_pos_next = pend_pos_reg;

        ctl.op    = prl_pkg::CELL_HOLD;
        ctl.pos   = pos_w;
        ctl.count = count_w;

        out_load   = 1'b0;
        out_status = prl_pkg::ST_OK;
        out_pos    = '0;
        out_rec    = '0;
        out_count  = count_w[4:0];
        out_last   = 1'b1;

        unique case (state_reg)
            prl_pkg::FSM_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_in) inside
                        prl_pkg::CMD_INSERT:
                        begin
                            out_load = 1'b1;
                            out_pos  = position[3:0];
                            if (count_w == CAP_W)
                                out_status = prl_pkg::ST_FULL;
                            else if (pos_w > count_w)
                                out_status = prl_pkg::ST_BADPOS;
                            else
                            begin
                                ctl.op     = prl_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                out_rec    = new_rec;
                                out_count  = count_inc_w[4:0];
                            end
                        end
                        prl_pkg::CMD_DELETE, prl_pkg::CMD_READ:
                        begin
                            if (pos_w >= count_w)
                            begin
                                out_load   = 1'b1;
                                out_status = prl_pkg::ST_BADPOS;
                                out_pos    = position[3:0];
                            end
                            else
                            begin
                                state_next = prl_pkg::FSM_SCAN;
                                cmd_next   = cmd_in;
                                pos_next   = pos_w[IDX_W-1:0];
                                k_next     = '0;
                            end
                        end
                        prl_pkg::CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                out_load   = 1'b1;
                                out_status = prl_pkg::ST_NOMATCH;
                            end
                            else
                            begin
                                state_next = prl_pkg::FSM_SCAN;
                                cmd_next   = cmd_in;
                                key_next   = title_key;
                                k_next     = '0;
                                n_next     = '0;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end

            prl_pkg::FSM_SCAN:
            begin
                // Rotate once around the occupied slots; slot 0 shows entry k
                ctl.op = prl_pkg::CELL_ROTATE;
                k_next = k_reg + IDX_W'(1);
                case (cmd_reg)
                    prl_pkg::CMD_READ:
                    begin
                        if (k_reg == pos_reg)
                        begin
                            out_load = 1'b1;
                            out_rec  = head;
                            out_pos  = k_w[3:0];
                        end
                    end
                    prl_pkg::CMD_DELETE:
                    begin
                        if (k_reg == pos_reg)
                        begin
                            out_load  = 1'b1;
                            out_rec   = head;
                            out_pos   = k_w[3:0];
                            out_count = count_dec_w[4:0];
                        end
                    end
                    prl_pkg::CMD_SEARCH:
                    begin
                        if (head.title == key_reg && n_reg != N_W'(prl_pkg::MAX_RESULTS))
                        begin
                            // Release the previous hit; the new one waits for its last flag
                            if (n_reg != '0)
                            begin
                                out_load = 1'b1;
                                out_rec  = pend_rec_reg;
                                out_pos  = pend_pos_w[3:0];
                                out_last = 1'b0;
                            end
                            pend_rec_next = head;
                            pend_pos_next = k_reg;
                            n_next        = n_reg + N_W'(1);
                        end
                    end
                    default:
                    begin
                        out_load = 1'b0;
                    end
                endcase
                if (k_w == count_dec_w)
                    state_next = (cmd_reg == prl_pkg::CMD_READ) ? prl_pkg::FSM_IDLE
                                                                : prl_pkg::FSM_FINISH;
            end

            prl_pkg::FSM_FINISH:
            begin
                state_next = prl_pkg::FSM_IDLE;
                if (cmd_reg == prl_pkg::CMD_DELETE)
                begin
                    // Close the gap left by the removed entry
                    ctl.op     = prl_pkg::CELL_DELETE;
                    ctl.pos    = CTL_W'(pos_reg);
                    count_next = count_reg - CNT_W'(1);
                end
                else if (cmd_reg == prl_pkg::CMD_SEARCH)
                begin
                    out_load = 1'b1;
                    if (n_reg == '0)
                        out_status = prl_pkg::ST_NOMATCH;
                    else
                    begin
                        out_rec = pend_rec_reg;
                        out_pos = pend_pos_w[3:0];
                    end
                end
            end

            default:
            begin
                state_next = prl_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prl_pkg::FSM_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= out_load;
        end
    end

    // Command context and result beat payload
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        pend_rec_reg <= pend_rec_next;
        pend_pos_reg <= pend_pos_next;
        if (out_load)
        begin
            status_reg    <= out_status;
            pos_out_reg   <= out_pos;
            rec_out_reg   <= out_rec;
            count_out_reg <= out_count;
            last_reg      <= out_last;
        end
    end

    assign busy           = (state_reg != prl_pkg::FSM_IDLE);
    assign valid          = valid_reg;
    assign status         = status_reg;
    assign entry_position = pos_out_reg;
    assign entry_title    = rec_out_reg.title;
    assign entry_genre    = rec_out_reg.genre;
    assign entry_year     = rec_out_reg.year;
    assign entry_rating   = rec_out_reg.rating;
    assign entry_count    = count_out_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_w <= CAP_W)
        else $error("entry count above capacity");

    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd_in == prl_pkg::CMD_INSERT && count_w == CAP_W)
        |=> (valid && status == prl_pkg::ST_FULL && $stable(count_reg)))
        else $error("insert into full list not refused");

    a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prl_pkg::FSM_FINISH && cmd_reg == prl_pkg::CMD_SEARCH)
        |=> (valid && last))
        else $error("search finished without a final beat");

    a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && status == prl_pkg::ST_NOMATCH) |-> last)
        else $error("no-match beat without last");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == prl_pkg::FSM_FINISH && cmd_reg == prl_pkg::CMD_DELETE)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("delete did not shrink the list");
`endif

endmodule

### sim/positional_record_list_checker.sv
`timescale 1ns / 1ps
// Checker for the positional record list: shadow list, expected result beats and field compare.
module positional_record_list_checker #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [4:0]  position,
    input  logic [63:0] title_key,
    input  logic [63:0] genre_key,
    input  logic [15:0] year,
    input  logic [9:0]  rating_tenths,
    input  logic        valid,
    input  logic [1:0]  status,
    input  logic [3:0]  entry_position,
    input  logic [63:0] entry_title,
    input  logic [63:0] entry_genre,
    input  logic [15:0] entry_year,
    input  logic [9:0]  entry_rating,
    input  logic [4:0]  entry_count,
    input  logic        last,
    output int          mismatch_count,
    output int          beats_outstanding
);

    localparam int PRINT_CAP = 40;

    typedef struct {
        prl_pkg::status_t status;
        logic [3:0]       pos;
        prl_pkg::rec_t    rec;
        logic [4:0]       count;
        logic             last;
    } beat_t;

    // Shadow copy of the list and the beats it still owes
    prl_pkg::rec_t shelf [CAPACITY];
    int            shelf_count;
    beat_t         owed_beats [$];
    int            errors = 0;

    // Build one result beat; the count is the shadow count after the operation
    function automatic beat_t make_beat(prl_pkg::status_t st, int pos, prl_pkg::rec_t rec,
                                        logic fin);
        beat_t b;
        b.status = st;
        b.pos    = pos[3:0];
        b.rec    = rec;
        b.count  = shelf_count[4:0];
        b.last   = fin;
        return b;
    endfunction

    // Apply one accepted command to the shadow list and queue the beats it causes
    task automatic apply_list_op(prl_pkg::cmd_t cmd, int pos, prl_pkg::rec_t arriving);
        prl_pkg::rec_t removed;
        beat_t         held;
        bit            have_hit;
        int            hits;
        case (cmd)
            prl_pkg::CMD_INSERT:
            begin
                if (shelf_count >= CAPACITY)
                    owed_beats.push_back(make_beat(prl_pkg::ST_FULL, pos, '0, 1'b1));
                else if (pos > shelf_count)
                    owed_beats.push_back(make_beat(prl_pkg::ST_BADPOS, pos, '0, 1'b1));
                else
                begin
                    // clamp rating, open a slot and store
                    if (arriving.rating > prl_pkg::RATING_MAX)
                        arriving.rating = prl_pkg::RATING_MAX;
                    for (int i = shelf_count; i > pos; i--)
                        shelf[i] = shelf[i-1];
                    shelf[pos] = arriving;
                    shelf_count++;
                    owed_beats.push_back(make_beat(prl_pkg::ST_OK, pos, shelf[pos], 1'b1));
                end
            end
            prl_pkg::CMD_DELETE, prl_pkg::CMD_READ:
            begin
                if (pos >= shelf_count)
                    owed_beats.push_back(make_beat(prl_pkg::ST_BADPOS, pos, '0, 1'b1));
                else if (cmd == prl_pkg::CMD_READ)
                    owed_beats.push_back(make_beat(prl_pkg::ST_OK, pos, shelf[pos], 1'b1));
                else
                begin
                    // close the gap left by the removed record
                    removed = shelf[pos];
                    for (int i = pos; i + 1 < shelf_count; i++)
                        shelf[i] = shelf[i+1];
                    shelf_count--;
                    owed_beats.push_back(make_beat(prl_pkg::ST_OK, pos, removed, 1'b1));
                end
            end
            default:
            begin
                // hold each hit back one step so the final one can carry last
                hits     = 0;
                have_hit = 1'b0;
                for (int i = 0; i < shelf_count && hits < prl_pkg::MAX_RESULTS; i++)
                begin
                    if (shelf[i].title == arriving.title)
                    begin
                        if (have_hit)
                            owed_beats.push_back(held);
                        held     = make_beat(prl_pkg::ST_OK, i, shelf[i], 1'b0);
                        have_hit = 1'b1;
                        hits++;
                    end
                end
                if (have_hit)
                begin
                    held.last = 1'b1;
                    owed_beats.push_back(held);
                end
                else
                    owed_beats.push_back(make_beat(prl_pkg::ST_NOMATCH, 0, '0, 1'b1));
            end
        endcase
    endtask

    // Print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= PRINT_CAP)
            $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $time);
    endtask

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            report_mismatch(what, want, got);
    endtask

    // Watch both channels at each edge: predict on accept, compare on strobe
    always @(posedge clk or negedge rst_n)
    begin : watch
        beat_t want;
        if (!rst_n)
        begin
            shelf_count = 0;
            owed_beats.delete();
            beats_outstanding <= 0;
            mismatch_count    <= errors;
        end
        else
        begin
            if (start === 1'b1 && busy === 1'b0)
                apply_list_op(prl_pkg::cmd_t'(command), int'(position),
                              {title_key, genre_key, year, rating_tenths});
            if (valid === 1'b1)
            begin
                if (owed_beats.size() == 0)
                    report_mismatch("unexpected beat, status", '0, 64'(status));
                else
                begin
                    want = owed_beats.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("entry_position", 64'(want.pos), 64'(entry_position));
                    check_field("entry_title", want.rec.title, entry_title);
                    check_field("entry_genre", want.rec.genre, entry_genre);
                    check_field("entry_year", 64'(want.rec.year), 64'(entry_year));
                    check_field("entry_rating", 64'(want.rec.rating), 64'(entry_rating));
                    check_field("entry_count", 64'(want.count), 64'(entry_count));
                    check_field("last", 64'(want.last), 64'(last));
                end
            end
            else if (valid !== 1'b0)
                report_mismatch("valid not known", '0, 64'(valid));
            beats_outstanding <= owed_beats.size();
            mismatch_count    <= errors;
        end
    end

endmodule

### sim/positional_record_list_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the positional record list: clock, reset, command stimulus and verdict.
module positional_record_list_top_tb;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 120;
    localparam logic [63:0] ALL_ONES = '1;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [4:0]  position;
    logic [63:0] title_key;
    logic [63:0] genre_key;
    logic [15:0] year;
    logic [9:0]  rating_tenths;
    logic        valid;
    logic [1:0]  status;
    logic [3:0]  entry_position;
    logic [63:0] entry_title;
    logic [63:0] entry_genre;
    logic [15:0] entry_year;
    logic [9:0]  entry_rating;
    logic [4:0]  entry_count;
    logic        last;

    int          mismatch_count;
    int          beats_outstanding;
    int          cycle_count = 0;
    int          idle_pct;
    int          fill;
    bit          growing;
    logic [63:0] title_pool [4];

    positional_record_list_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .position(position),
        .title_key(title_key),
        .genre_key(genre_key),
        .year(year),
        .rating_tenths(rating_tenths),
        .valid(valid),
        .status(status),
        .entry_position(entry_position),
        .entry_title(entry_title),
        .entry_genre(entry_genre),
        .entry_year(entry_year),
        .entry_rating(entry_rating),
        .entry_count(entry_count),
        .last(last)
    );

    positional_record_list_checker #(
        .CAPACITY(CAPACITY)
    ) list_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .position(position),
        .title_key(title_key),
        .genre_key(genre_key),
        .year(year),
        .rating_tenths(rating_tenths),
        .valid(valid),
        .status(status),
        .entry_position(entry_position),
        .entry_title(entry_title),
        .entry_genre(entry_genre),
        .entry_year(entry_year),
        .entry_rating(entry_rating),
        .entry_count(entry_count),
        .last(last),
        .mismatch_count(mismatch_count),
        .beats_outstanding(beats_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one command beat, idle at random first, hold until accepted
    task automatic send_command(prl_pkg::cmd_t cmd, int pos, logic [63:0] t, logic [63:0] g,
                                logic [15:0] y, logic [9:0] r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        command       <= cmd;
        position      <= pos[4:0];
        title_key     <= t;
        genre_key     <= g;
        year          <= y;
        rating_tenths <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // track the list size to aim positions
        case (cmd)
            prl_pkg::CMD_INSERT: if (fill < CAPACITY && pos <= fill) fill++;
            prl_pkg::CMD_DELETE: if (pos < fill) fill--;
            default: ;
        endcase
    endtask

    // Drop start and hold off until every owed beat has come
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (beats_outstanding != 0);
    endtask

    // One random command, mostly well aimed, drifting between empty and full
    task automatic send_random();
        int            roll;
        int            pos;
        prl_pkg::cmd_t cmd;
        logic [63:0]   t;
        logic [9:0]    r;
        if (fill >= CAPACITY)
            growing = 1'b0;
        else if (fill == 0)
            growing = 1'b1;
        roll = $urandom_range(99);
        if (roll < (growing ? 50 : 15))
            cmd = prl_pkg::CMD_INSERT;
        else if (roll < 65)
            cmd = prl_pkg::CMD_DELETE;
        else if (roll < 82)
            cmd = prl_pkg::CMD_READ;
        else
            cmd = prl_pkg::CMD_SEARCH;
        // aim at a legal position most of the time
        if ($urandom_range(99) < 85 && cmd != prl_pkg::CMD_SEARCH)
        begin
            if (cmd == prl_pkg::CMD_INSERT)
                pos = $urandom_range(fill, 0);
            else
                pos = (fill > 0) ? $urandom_range(fill - 1, 0) : 0;
        end
        else
            pos = $urandom_range(16, 0);
        if ($urandom_range(99) < 75)
            t = title_pool[2'($urandom_range(3, 0))];
        else
            t = {$urandom, $urandom};
        if ($urandom_range(99) < 90)
            r = 10'($urandom_range(1000, 0));
        else
            r = 10'($urandom_range(1023, 1001));
        send_command(cmd, pos, t, {$urandom, $urandom}, 16'($urandom_range(65535, 0)), r);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        command       = prl_pkg::CMD_INSERT;
        position      = '0;
        title_key     = '0;
        genre_key     = '0;
        year          = '0;
        rating_tenths = '0;
        idle_pct      = 0;
        fill          = 0;
        growing       = 1'b1;
        title_pool[0] = ALL_ONES;
        title_pool[1] = '0;
        title_pool[2] = {$urandom, $urandom};
        title_pool[3] = {$urandom, $urandom};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every access refused, search finds nothing
        send_command(prl_pkg::CMD_READ, 0, '0, '0, '0, '0);
        send_command(prl_pkg::CMD_DELETE, 0, '0, '0, '0, '0);
        send_command(prl_pkg::CMD_SEARCH, 0, ALL_ONES, '0, '0, '0);
        send_command(prl_pkg::CMD_INSERT, 1, ALL_ONES, '0, '0, '0);

        // field extremes, over-range rating, insert at front, end and middle
        send_command(prl_pkg::CMD_INSERT, 0, ALL_ONES, '0, 16'hFFFF, 10'd1023);
        send_command(prl_pkg::CMD_INSERT, 0, '0, ALL_ONES, '0, '0);
        send_command(prl_pkg::CMD_INSERT, 2, ALL_ONES, {$urandom, $urandom}, 16'd1999,
                     10'd1000);
        send_command(prl_pkg::CMD_INSERT, 1, title_pool[2], {$urandom, $urandom}, 16'd2024,
                     10'd77);
        send_command(prl_pkg::CMD_SEARCH, 16, ALL_ONES, '0, '0, '0);
        send_command(prl_pkg::CMD_SEARCH, 0, '0, '0, '0, '0);
        send_command(prl_pkg::CMD_READ, 3, '0, '0, '0, '0);
        send_command(prl_pkg::CMD_READ, 16, '0, '0, '0, '0);
        send_command(prl_pkg::CMD_DELETE, 4, '0, '0, '0, '0);

        // delete from the middle and the front, leaving two matching titles
        send_command(prl_pkg::CMD_DELETE, 1, '0, '0, '0, '0);
        send_command(prl_pkg::CMD_DELETE, 0, '0, '0, '0, '0);

        // fill up with one title so a search hits every slot
        while (fill < CAPACITY)
            send_command(prl_pkg::CMD_INSERT, $urandom_range(fill, 0), ALL_ONES,
                         {$urandom, $urandom}, 16'($urandom_range(65535, 0)),
                         10'($urandom_range(1000, 0)));
        send_command(prl_pkg::CMD_INSERT, 16, ALL_ONES, '0, '0, '0);
        send_command(prl_pkg::CMD_SEARCH, 0, ALL_ONES, '0, '0, '0);
        send_command(prl_pkg::CMD_DELETE, 15, '0, '0, '0, '0);
        wait_drained();

        // random traffic under several idle patterns
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 67;
                2: idle_pct = 0;
                default: idle_pct = 35;
            endcase
            repeat (PHASE_ITEMS) send_random();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && beats_outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
design/prl_pkg.sv
design/prl_cell.sv
design/positional_record_list_top.sv
sim/positional_record_list_checker.sv
sim/positional_record_list_top_tb.sv
